// ===== sv/smeu_pkg.sv =====
package smeu_pkg;

  // Sizes of the register file and the stack store
  localparam int STACK_DEPTH = 256;
  localparam int REG_COUNT   = 8;
  localparam int WORD_W      = 32;
  localparam int REG_W       = 3;
  localparam int SA_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Fixed register roles
  localparam logic [REG_W-1:0] IP_IDX = REG_W'(6);
  localparam logic [REG_W-1:0] SP_IDX = REG_W'(7);

  // Iterative divider: one quotient bit per cycle
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    MODE_PUSH = 4'd0,
    MODE_POP  = 4'd1,
    MODE_HALT = 4'd2,
    MODE_SET  = 4'd3,
    MODE_MOVE = 4'd4,
    MODE_ADD  = 4'd5,
    MODE_SUB  = 4'd6,
    MODE_MUL  = 4'd7,
    MODE_DIV  = 4'd8,
    MODE_NONE = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDX,
    ST_RDY,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src_reg;
    logic [WORD_W-1:0] immediate;
  } smeu_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] next_ip;
    logic              pop_valid;
    logic [WORD_W-1:0] pop_value;
    logic              halted;
    logic              fault;
  } smeu_out_t;

endpackage

// ===== sv/smeu_div.sv =====
module smeu_div
  import smeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    dvs;
  logic [WORD_W:0]      rem_sh;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, quo[WORD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= WORD_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[WORD_W-1:0];
      end
      quo <= {quo[WORD_W-2:0], fits};
    end
  end

endmodule

// ===== sv/stack_machine_execute_unit.sv =====
// Stack machine execute unit.
// Input channel (in_valid/in_ready/in_data) takes one decoded instruction per
// request; output channel (out_valid/out_ready/out_data) returns exactly one
// result per request, in order: the new instruction pointer, the popped word,
// the halted flag and the fault flag.
// The stack lives in a synchronous single-write, single-read memory with a
// registered read; the eight registers are flip-flops.
// Steps per request, from acceptance to the commit step, where the result is
// loaded into the output register as in_ready rises again:
//   push, set, move, halt, unknown codes and anything after a halt: commit only
//   pop: one stack read; add, sub, mul, div by zero: two stack reads
//   div: two stack reads, then the divider for a non-zero divisor, one bit a cycle.
// One request is in flight at a time; in_ready is high only while idle.
// The result sits in an output register, so the next request is taken while
// it waits. If the receiver stalls, the following request holds in its final
// step until the output register frees, and state updates wait with it.
// After reset the stack memory is cleared one word a cycle, all STACK_DEPTH
// words, during which in_ready stays low. Registers reset to zero except the
// stack pointer, which resets to all ones (empty stack).
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  smeu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output smeu_out_t out_data
);

  state_t            state;
  state_t            state_next;
  logic [WORD_W-1:0] regs [REG_COUNT];
  logic [WORD_W-1:0] regs_next [REG_COUNT];
  logic              running;
  logic              running_next;
  smeu_in_t          item;
  logic [WORD_W-1:0] x_word;
  logic [WORD_W-1:0] res;
  logic              fault_acc;
  logic [SA_W-1:0]   clr_addr;
  smeu_out_t         out_next;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [SA_W-1:0]   mem_raddr;
  logic [SA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_we;

  logic              accept;
  logic              commit;
  logic              out_free;
  logic [WORD_W-1:0] ip;
  logic [WORD_W-1:0] sp;
  logic [WORD_W-1:0] sp_inc;
  logic [WORD_W-1:0] sp_dec;
  logic              sp_oob;
  logic              inc_oob;
  logic              dec_oob;
  logic              is_arith;
  logic [WORD_W-1:0] y_word;
  logic              wr_fault;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;

  // Stack pointer neighbours and their range checks
  assign ip       = regs[IP_IDX];
  assign sp       = regs[SP_IDX];
  assign sp_inc   = sp + 1'b1;
  assign sp_dec   = sp - 1'b1;
  assign sp_oob   = sp >= WORD_W'(STACK_DEPTH);
  assign inc_oob  = sp_inc >= WORD_W'(STACK_DEPTH);
  assign dec_oob  = sp_dec >= WORD_W'(STACK_DEPTH);
  assign is_arith = (item.mode == MODE_ADD) || (item.mode == MODE_SUB) ||
                    (item.mode == MODE_MUL) || (item.mode == MODE_DIV);

  assign in_ready  = state == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign commit    = (state == ST_COMMIT) && out_free;
  assign y_word    = dec_oob ? '0 : rdata;
  assign div_start = (state == ST_RDY) && (item.mode == MODE_DIV) && (x_word != '0);

  // Top of stack on acceptance, the word below it afterwards
  assign mem_raddr = (state == ST_IDLE) ? sp[SA_W-1:0] : sp_dec[SA_W-1:0];

  // Stack memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  smeu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (y_word),
    .divisor  (x_word),
    .done     (div_done),
    .quotient (div_quo)
  );

  // State register, clear counter, registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      running  <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= (REG_W'(i) == SP_IDX) ? '1 : '0;
      end
    end else begin
      state   <= state_next;
      running <= running_next;
      regs    <= regs_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand capture and result computation
  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= in_data;
      fault_acc <= 1'b0;
    end
    case (state)
      ST_RDX: begin
        x_word    <= sp_oob ? '0 : rdata;
        fault_acc <= fault_acc | sp_oob;
      end
      ST_RDY: begin
        // Divide by zero gives zero and raises fault
        fault_acc <= fault_acc | dec_oob | ((item.mode == MODE_DIV) && (x_word == '0));
        case (item.mode)
          MODE_ADD: res <= y_word + x_word;
          MODE_SUB: res <= y_word - x_word;
          MODE_MUL: res <= WORD_W'(y_word * x_word);
          default:  res <= '0;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          res <= div_quo;
        end
      end
      default: ;
    endcase
    if (commit) begin
      out_data <= out_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SA_W'(STACK_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (running && ((in_data.mode == MODE_POP) || (in_data.mode == MODE_ADD) ||
                          (in_data.mode == MODE_SUB) || (in_data.mode == MODE_MUL) ||
                          (in_data.mode == MODE_DIV))) begin
            state_next = ST_RDX;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_RDX:  state_next = is_arith ? ST_RDY : ST_COMMIT;
      ST_RDY:  state_next = div_start ? ST_DIV : ST_COMMIT;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commit: register and stack write-back, result assembly; clear sweep
  always_comb begin
    regs_next    = regs;
    running_next = running;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr;
    mem_wdata    = '0;
    wr_fault     = 1'b0;
    out_next     = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end
    if (commit) begin
      if (running) begin
        case (item.mode)
          MODE_PUSH: begin
            regs_next[IP_IDX] = ip + 1'b1;
            regs_next[SP_IDX] = sp_inc;
            mem_we    = !inc_oob;
            mem_waddr = sp_inc[SA_W-1:0];
            mem_wdata = item.immediate;
            wr_fault  = inc_oob;
          end
          MODE_POP: begin
            regs_next[SP_IDX]  = sp_dec;
            out_next.pop_valid = 1'b1;
            out_next.pop_value = x_word;
          end
          MODE_HALT: running_next = 1'b0;
          MODE_SET: begin
            regs_next[IP_IDX]        = ip + WORD_W'(2);
            regs_next[item.dest_reg] = item.immediate;
          end
          MODE_MOVE: begin
            regs_next[IP_IDX] = ip + WORD_W'(2);
            regs_next[item.dest_reg] = (item.src_reg == IP_IDX) ? ip + WORD_W'(2)
                                                                 : regs[item.src_reg];
          end
          MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
            regs_next[SP_IDX] = sp_dec;
            mem_we    = !dec_oob;
            mem_waddr = sp_dec[SA_W-1:0];
            mem_wdata = res;
            wr_fault  = dec_oob;
          end
          default: ;
        endcase
        regs_next[IP_IDX] = regs_next[IP_IDX] + 1'b1;
      end
      out_next.next_ip = regs_next[IP_IDX];
      out_next.halted  = !running_next;
      out_next.fault   = fault_acc | wr_fault;
    end
  end

endmodule

// ===== sv/smeu_checker.sv =====
module smeu_checker
  import smeu_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input smeu_out_t out_data
);

  logic halted_seen;

  // Remember that a halted result has been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      halted_seen <= 1'b0;
    end else if (out_valid && out_ready && out_data.halted) begin
      halted_seen <= 1'b1;
    end
  end

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Keep requests off straight after reset, as the clearing sweep begins
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken straight after reset");

  // Take one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // After a halt, results stay halted and inert
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted_seen |->
      out_data.halted && !out_data.pop_valid && !out_data.fault)
    else $error("activity after halt");

  // Carry a popped word only on a pop
  a_pop_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pop_valid |-> out_data.pop_value == '0)
    else $error("pop value set on a non-pop result");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tb_stack_machine_execute_unit.sv =====
module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 37;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;
  localparam int RAND_ITEMS  = 1100;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  smeu_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  smeu_out_t out_data;

  // Predicted machine state
  logic [WORD_W-1:0] gpr [REG_COUNT];
  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  logic              is_running;
  logic              bad_access;

  smeu_out_t results_due [$];
  int        error_count;
  int        gap_pct;
  int        stall_cycles;

  stack_machine_execute_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stack accesses outside the store flag a fault; reads give zero, writes drop
  function automatic logic [WORD_W-1:0] stack_rd(logic [WORD_W-1:0] addr);
    if (addr >= WORD_W'(STACK_DEPTH)) begin
      bad_access = 1'b1;
      return '0;
    end
    return stack_words[addr[SA_W-1:0]];
  endfunction

  function automatic void stack_wr(logic [WORD_W-1:0] addr, logic [WORD_W-1:0] val);
    if (addr >= WORD_W'(STACK_DEPTH)) begin
      bad_access = 1'b1;
      return;
    end
    stack_words[addr[SA_W-1:0]] = val;
  endfunction

  function automatic void clear_machine();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (stack_words[i]) stack_words[i] = '0;
    gpr[SP_IDX] = '1;
    is_running = 1'b1;
  endfunction

  // Execute one instruction on the predicted state and return its result
  function automatic smeu_out_t exec_instr(smeu_in_t ins);
    smeu_out_t         res;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] w;
    logic              div_zero;
    res = '0;
    div_zero = 1'b0;
    bad_access = 1'b0;
    if (is_running) begin
      case (ins.mode)
        MODE_PUSH: begin
          gpr[IP_IDX] += 1;
          gpr[SP_IDX] += 1;
          stack_wr(gpr[SP_IDX], ins.immediate);
        end
        MODE_POP: begin
          res.pop_value = stack_rd(gpr[SP_IDX]);
          res.pop_valid = 1'b1;
          gpr[SP_IDX] -= 1;
        end
        MODE_HALT: begin
          is_running = 1'b0;
        end
        MODE_SET: begin
          gpr[IP_IDX] += 2;
          gpr[ins.dest_reg] = ins.immediate;
        end
        MODE_MOVE: begin
          gpr[IP_IDX] += 2;
          gpr[ins.dest_reg] = gpr[ins.src_reg];
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
          x = stack_rd(gpr[SP_IDX]);
          gpr[SP_IDX] -= 1;
          y = stack_rd(gpr[SP_IDX]);
          gpr[SP_IDX] -= 1;
          case (ins.mode)
            MODE_ADD: w = y + x;
            MODE_SUB: w = y - x;
            MODE_MUL: w = y * x;
            default: begin
              if (x == '0) begin
                div_zero = 1'b1;
                w = '0;
              end else begin
                w = y / x;
              end
            end
          endcase
          gpr[SP_IDX] += 1;
          stack_wr(gpr[SP_IDX], w);
        end
        default: ;
      endcase
      gpr[IP_IDX] += 1;
    end
    res.next_ip = gpr[IP_IDX];
    res.halted  = ~is_running;
    res.fault   = bad_access | div_zero;
    return res;
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    return REG_W'($urandom_range(0, REG_COUNT - 1));
  endfunction

  // Mix of full-range words, small values and the extremes
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(WORD_W - 1){1'b0}}};
      3, 4, 5: return WORD_W'($urandom_range(0, 20));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Send one request; valid stays high from one request to the next unless idling
  task automatic issue(input logic [3:0] code, input logic [REG_W-1:0] dst,
                       input logic [REG_W-1:0] src, input logic [WORD_W-1:0] imm);
    smeu_in_t ins;
    ins.mode      = code;
    ins.dest_reg  = dst;
    ins.src_reg   = src;
    ins.immediate = imm;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.insert(results_due.size(), exec_instr(ins));
  endtask

  // Stack extremes, every operation but halt and the fault cases
  task automatic test_directed();
    gap_pct = IDLE_PCT;
    issue(MODE_POP, '0, '0, '0);
    issue(MODE_SET, SP_IDX, '0, '1);
    issue(MODE_PUSH, '0, '0, '1);
    issue(MODE_PUSH, '0, '0, '0);
    issue(MODE_DIV, '0, '0, '0);
    issue(MODE_PUSH, '0, '0, 32'd100);
    issue(MODE_PUSH, '0, '0, 32'd7);
    issue(MODE_DIV, '0, '0, '0);
    issue(MODE_PUSH, '0, '0, 32'hFFFF_FFFD);
    issue(MODE_MUL, '0, '0, '0);
    issue(MODE_PUSH, '0, '0, 32'd50);
    issue(MODE_SUB, '0, '0, '0);
    issue(MODE_PUSH, '0, '0, {1'b1, {(WORD_W - 1){1'b0}}});
    issue(MODE_ADD, '0, '0, '0);
    issue(MODE_POP, '0, '0, '0);
    issue(MODE_SET, REG_W'(5), '0, 32'hA5A5_5A5A);
    issue(MODE_MOVE, '0, REG_W'(5), '0);
    issue(MODE_MOVE, REG_W'(3), IP_IDX, '0);
    issue(MODE_MOVE, REG_W'(4), SP_IDX, '0);
    issue(MODE_SET, IP_IDX, '0, '1);
    issue(MODE_NONE, '1, '1, '1);
    issue(4'($urandom_range(int'(MODE_NONE) + 1, (1 << $bits(mode_t)) - 1)), '0, '0, '0);
    issue(MODE_SET, SP_IDX, '0, WORD_W'(STACK_DEPTH - 1));
    issue(MODE_PUSH, '0, '0, 32'h1234_5678);
    issue(MODE_ADD, '0, '0, '0);
  endtask

  // Random programs, mostly well-formed stack traffic with some noise
  task automatic test_random_programs(input int count);
    int                pick;
    logic              sp_ok;
    logic [WORD_W-1:0] depth;
    logic [REG_W-1:0]  dst;
    for (int n = 0; n < count; n++) begin
      gap_pct = (n >= count / 3 && n < count / 2) ? 0 : IDLE_PCT;
      sp_ok = (gpr[SP_IDX] < WORD_W'(STACK_DEPTH)) || (gpr[SP_IDX] == '1);
      depth = gpr[SP_IDX] + 1;
      pick  = $urandom_range(0, 99);
      dst   = rand_reg();
      if (!sp_ok && pick < 60) begin
        // bring the stack pointer back into the store
        issue(MODE_SET, SP_IDX, rand_reg(),
              ($urandom_range(0, 1) != 0) ? '1 : WORD_W'($urandom_range(0, 7)));
      end else if (pick < 32) begin
        if (depth > WORD_W'(STACK_DEPTH - 8) && $urandom_range(0, 1) != 0)
          issue(MODE_POP, dst, rand_reg(), WORD_W'($urandom));
        else
          issue(MODE_PUSH, dst, rand_reg(), rand_word());
      end else if (pick < 44) begin
        issue(MODE_POP, dst, rand_reg(), WORD_W'($urandom));
      end else if (pick < 70) begin
        issue(4'($urandom_range(MODE_ADD, MODE_DIV)), dst, rand_reg(), WORD_W'($urandom));
      end else if (pick < 78) begin
        if (dst == SP_IDX && $urandom_range(0, 4) != 0)
          issue(MODE_SET, dst, rand_reg(), WORD_W'($urandom_range(0, STACK_DEPTH - 1)));
        else
          issue(MODE_SET, dst, rand_reg(), rand_word());
      end else if (pick < 86) begin
        issue(MODE_MOVE, dst, rand_reg(), WORD_W'($urandom));
      end else if (pick < 92) begin
        issue(MODE_NONE, dst, rand_reg(), WORD_W'($urandom));
      end else if (pick < 96) begin
        issue(4'($urandom_range(int'(MODE_NONE) + 1, (1 << $bits(mode_t)) - 1)),
              dst, rand_reg(), WORD_W'($urandom));
      end else begin
        // wild writes to the pointer registers
        issue(MODE_SET, ($urandom_range(0, 1) != 0) ? SP_IDX : IP_IDX, rand_reg(),
              WORD_W'($urandom));
      end
    end
  endtask

  // Halt, then check that every kind of request is ignored afterwards
  task automatic test_halt();
    gap_pct = IDLE_PCT;
    issue(MODE_PUSH, '0, '0, 32'd9);
    issue(MODE_HALT, rand_reg(), rand_reg(), WORD_W'($urandom));
    for (int m = 0; m < (1 << $bits(mode_t)); m++)
      issue(4'(m), rand_reg(), rand_reg(), WORD_W'($urandom));
  endtask

  // Hold off until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    error_count++;
  endtask

  // Receiver stalls at the same rate as the sender idles
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= gap_pct);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    smeu_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $realtime, out_data);
        error_count++;
      end else begin
        exp_r = results_due.pop_front();
        if (out_data.next_ip !== exp_r.next_ip)
          report_field("next_ip", exp_r.next_ip, out_data.next_ip);
        if (out_data.pop_valid !== exp_r.pop_valid)
          report_field("pop_valid", WORD_W'(exp_r.pop_valid), WORD_W'(out_data.pop_valid));
        if (out_data.pop_value !== exp_r.pop_value)
          report_field("pop_value", exp_r.pop_value, out_data.pop_value);
        if (out_data.halted !== exp_r.halted)
          report_field("halted", WORD_W'(exp_r.halted), WORD_W'(out_data.halted));
        if (out_data.fault !== exp_r.fault)
          report_field("fault", WORD_W'(exp_r.fault), WORD_W'(out_data.fault));
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_stack_machine_execute_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    gap_pct      = IDLE_PCT;
    clear_machine();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_programs(RAND_ITEMS);
    test_halt();
    drain();
    if (error_count == 0) begin
      $display("tb_stack_machine_execute_unit: clean");
    end else begin
      $display("tb_stack_machine_execute_unit: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/smeu_pkg.sv
sv/smeu_div.sv
sv/stack_machine_execute_unit.sv
sv/smeu_checker.sv
tb/tb_stack_machine_execute_unit.sv
